// ----- rtl/efr_pkg.sv -----
// ----------------------------------------------------------------------------
// efr_pkg: shared types and constants of the edge function raster block
// Coordinate widths, the command queue entry, the scan issue record and the
// result record that travel between the front, the scan and the edge stages.
// ----------------------------------------------------------------------------
`default_nettype none

package efr_pkg;

  localparam int CoordBits  = 9;
  localparam int ColorBits  = 24;
  localparam int QueueDepth = 2;
  localparam int QPtrBits   = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QCntBits   = $clog2(QueueDepth + 1);
  localparam int DiffBits   = CoordBits + 1;
  localparam int ProdBits   = 2 * DiffBits;
  localparam int EdgeBits   = ProdBits + 1;

  typedef logic [CoordBits-1:0]        coord_t;
  typedef logic [ColorBits-1:0]        color_t;
  typedef logic signed [DiffBits-1:0]  diff_t;
  typedef logic signed [ProdBits-1:0]  prod_t;
  typedef logic signed [EdgeBits-1:0]  edge_t;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_STEP = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t kind;
    coord_t    ax;
    coord_t    ay;
    coord_t    bx;
    coord_t    by;
    coord_t    cx;
    coord_t    cy;
    color_t    color;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_deq_t;

  typedef struct packed {
    logic   valid;
    coord_t px;
    coord_t py;
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by;
    coord_t cx;
    coord_t cy;
    color_t color;
    logic   last;
  } issue_t;

  typedef struct packed {
    logic   strobe;
    coord_t pos_x;
    coord_t pos_y;
    logic   covered;
    color_t color;
    logic   last;
  } result_t;

  function automatic coord_t min3(input coord_t a, input coord_t b, input coord_t c);
    coord_t m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  function automatic coord_t max3(input coord_t a, input coord_t b, input coord_t c);
    coord_t m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/efr_front.sv -----
// ----------------------------------------------------------------------------
// efr_front: command intake and queue
// Takes a transaction, tags it as a load or a step and queues it for the scan.
// ----------------------------------------------------------------------------
`default_nettype none

module efr_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  output logic                 busy,
  input  wire logic            in_req_type,
  input  wire efr_pkg::coord_t in_ax,
  input  wire efr_pkg::coord_t in_ay,
  input  wire efr_pkg::coord_t in_bx,
  input  wire efr_pkg::coord_t in_by_coord,
  input  wire efr_pkg::coord_t in_cx,
  input  wire efr_pkg::coord_t in_cy,
  input  wire efr_pkg::color_t in_fill_color,
  output efr_pkg::cmd_deq_t    deq
);

  efr_pkg::cmd_t                  mem_r [efr_pkg::QueueDepth];
  logic [efr_pkg::QPtrBits-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [efr_pkg::QPtrBits-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [efr_pkg::QCntBits-1:0]   count_r, count_nxt;
  efr_pkg::cmd_t                  new_cmd;
  logic                           push;
  logic                           pop;

  function automatic logic [efr_pkg::QPtrBits-1:0] ptr_inc(
    input logic [efr_pkg::QPtrBits-1:0] p);
    return (p == efr_pkg::QPtrBits'(efr_pkg::QueueDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  assign busy = (count_r == efr_pkg::QCntBits'(efr_pkg::QueueDepth));
  assign push = start && !busy;
  // The scan side takes one entry every cycle while the queue is not empty.
  assign pop  = (count_r != '0);

  always_comb begin
    new_cmd.kind  = in_req_type ? efr_pkg::CMD_STEP : efr_pkg::CMD_LOAD;
    new_cmd.ax    = in_ax;
    new_cmd.ay    = in_ay;
    new_cmd.bx    = in_bx;
    new_cmd.by    = in_by_coord;
    new_cmd.cx    = in_cx;
    new_cmd.cy    = in_cy;
    new_cmd.color = in_fill_color;
  end

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop  ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + efr_pkg::QCntBits'(push) - efr_pkg::QCntBits'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= new_cmd;
    end
  end

  assign deq.valid = pop;
  assign deq.cmd   = mem_r[rd_ptr_r];

endmodule

`default_nettype wire

// ----- rtl/efr_scan.sv -----
// ----------------------------------------------------------------------------
// efr_scan: triangle store and bounding box scan sequencer
// Holds the vertices, color and box of the current triangle and walks the
// box column by column, issuing one position per step command while active.
// ----------------------------------------------------------------------------
`default_nettype none

module efr_scan (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire efr_pkg::cmd_deq_t deq,
  output efr_pkg::issue_t        issue
);

  efr_pkg::coord_t ax_r, ay_r, bx_r, by_r, cx_r, cy_r;
  efr_pkg::coord_t min_x_r, max_x_r, min_y_r, max_y_r;
  efr_pkg::coord_t scan_x_r, scan_x_nxt;
  efr_pkg::coord_t scan_y_r, scan_y_nxt;
  efr_pkg::color_t color_r;
  logic            active_r, active_nxt;
  logic            do_load;
  logic            do_step;
  logic            last;
  efr_pkg::coord_t ld_min_x, ld_max_x, ld_min_y, ld_max_y;

  assign do_load = deq.valid && (deq.cmd.kind == efr_pkg::CMD_LOAD);
  assign do_step = deq.valid && (deq.cmd.kind == efr_pkg::CMD_STEP) && active_r;
  assign last    = (scan_x_r >= max_x_r) && (scan_y_r >= max_y_r);

  assign ld_min_x = efr_pkg::min3(deq.cmd.ax, deq.cmd.bx, deq.cmd.cx);
  assign ld_max_x = efr_pkg::max3(deq.cmd.ax, deq.cmd.bx, deq.cmd.cx);
  assign ld_min_y = efr_pkg::min3(deq.cmd.ay, deq.cmd.by, deq.cmd.cy);
  assign ld_max_y = efr_pkg::max3(deq.cmd.ay, deq.cmd.by, deq.cmd.cy);

  always_comb begin
    scan_x_nxt = scan_x_r;
    scan_y_nxt = scan_y_r;
    active_nxt = active_r;
    priority if (do_load) begin
      scan_x_nxt = ld_min_x;
      scan_y_nxt = ld_min_y;
      active_nxt = 1'b1;
    end else if (do_step) begin
      priority if (last) begin
        active_nxt = 1'b0;
      end else if (scan_y_r < max_y_r) begin
        scan_y_nxt = scan_y_r + 1'b1;
      end else begin
        scan_y_nxt = min_y_r;
        scan_x_nxt = scan_x_r + 1'b1;
      end
    end else begin
      active_nxt = active_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_x_r <= scan_x_nxt;
    scan_y_r <= scan_y_nxt;
    if (do_load) begin
      ax_r    <= deq.cmd.ax;
      ay_r    <= deq.cmd.ay;
      bx_r    <= deq.cmd.bx;
      by_r    <= deq.cmd.by;
      cx_r    <= deq.cmd.cx;
      cy_r    <= deq.cmd.cy;
      color_r <= deq.cmd.color;
      min_x_r <= ld_min_x;
      max_x_r <= ld_max_x;
      min_y_r <= ld_min_y;
      max_y_r <= ld_max_y;
    end
  end

  always_comb begin
    issue.valid = do_step;
    issue.px    = scan_x_r;
    issue.py    = scan_y_r;
    issue.ax    = ax_r;
    issue.ay    = ay_r;
    issue.bx    = bx_r;
    issue.by    = by_r;
    issue.cx    = cx_r;
    issue.cy    = cy_r;
    issue.color = color_r;
    issue.last  = last;
  end

  a_scan_x_in_box: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (scan_x_r >= min_x_r) && (scan_x_r <= max_x_r))
    else $error("scan x left the bounding box");

  a_scan_y_in_box: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (scan_y_r >= min_y_r) && (scan_y_r <= max_y_r))
    else $error("scan y left the bounding box");

  a_last_ends_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (issue.valid && issue.last) |=> !active_r)
    else $error("scan still active after the last position");

endmodule

`default_nettype wire

// ----- rtl/efr_edge.sv -----
// ----------------------------------------------------------------------------
// efr_edge: pipelined edge function test
// Three stages: coordinate differences, cross products, then the sign test
// that drives the result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module efr_edge (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire efr_pkg::issue_t issue,
  output efr_pkg::result_t     result
);

  // Edge lanes: A to B, B to C, C to A.
  efr_pkg::coord_t ex [3];
  efr_pkg::coord_t ey [3];
  efr_pkg::coord_t fx [3];
  efr_pkg::coord_t fy [3];

  // Stage 1: differences.
  logic            s1_valid_r;
  efr_pkg::coord_t s1_px_r, s1_py_r;
  efr_pkg::color_t s1_color_r;
  logic            s1_last_r;
  efr_pkg::diff_t  epx_r [3];
  efr_pkg::diff_t  epy_r [3];
  efr_pkg::diff_t  efx_r [3];
  efr_pkg::diff_t  efy_r [3];

  // Stage 2: products.
  logic            s2_valid_r;
  efr_pkg::coord_t s2_px_r, s2_py_r;
  efr_pkg::color_t s2_color_r;
  logic            s2_last_r;
  efr_pkg::prod_t  pa_r [3];
  efr_pkg::prod_t  pb_r [3];

  // Stage 3: sign test.
  efr_pkg::edge_t  e_val [3];
  logic            all_nonneg;
  logic            all_nonpos;
  efr_pkg::result_t res_r;

  always_comb begin
    ex[0] = issue.ax;  ey[0] = issue.ay;  fx[0] = issue.bx;  fy[0] = issue.by;
    ex[1] = issue.bx;  ey[1] = issue.by;  fx[1] = issue.cx;  fy[1] = issue.cy;
    ex[2] = issue.cx;  ey[2] = issue.cy;  fx[2] = issue.ax;  fy[2] = issue.ay;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      res_r      <= '0;
    end else begin
      s1_valid_r    <= issue.valid;
      s2_valid_r    <= s1_valid_r;
      res_r.strobe  <= s2_valid_r;
      res_r.pos_x   <= s2_px_r;
      res_r.pos_y   <= s2_py_r;
      res_r.covered <= all_nonneg || all_nonpos;
      res_r.color   <= s2_color_r;
      res_r.last    <= s2_last_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_px_r    <= issue.px;
    s1_py_r    <= issue.py;
    s1_color_r <= issue.color;
    s1_last_r  <= issue.last;
    for (int k = 0; k < 3; k++) begin
      epx_r[k] <= $signed({1'b0, ex[k]}) - $signed({1'b0, issue.px});
      epy_r[k] <= $signed({1'b0, ey[k]}) - $signed({1'b0, issue.py});
      efx_r[k] <= $signed({1'b0, fx[k]}) - $signed({1'b0, ex[k]});
      efy_r[k] <= $signed({1'b0, fy[k]}) - $signed({1'b0, ey[k]});
    end
  end

  always_ff @(posedge clk) begin
    s2_px_r    <= s1_px_r;
    s2_py_r    <= s1_py_r;
    s2_color_r <= s1_color_r;
    s2_last_r  <= s1_last_r;
    for (int k = 0; k < 3; k++) begin
      pa_r[k] <= efr_pkg::prod_t'(epx_r[k]) * efr_pkg::prod_t'(efy_r[k]);
      pb_r[k] <= efr_pkg::prod_t'(efx_r[k]) * efr_pkg::prod_t'(epy_r[k]);
    end
  end

  always_comb begin
    all_nonneg = 1'b1;
    all_nonpos = 1'b1;
    for (int k = 0; k < 3; k++) begin
      e_val[k]   = efr_pkg::edge_t'(pa_r[k]) - efr_pkg::edge_t'(pb_r[k]);
      all_nonneg = all_nonneg && !e_val[k][efr_pkg::EdgeBits-1];
      all_nonpos = all_nonpos && (e_val[k][efr_pkg::EdgeBits-1] || (e_val[k] == '0));
    end
  end

  assign result = res_r;

endmodule

`default_nettype wire

// ----- rtl/edge_function_triangle_raster.sv -----
// ----------------------------------------------------------------------------
// edge_function_triangle_raster: bounding box edge function rasterizer
// Loads a flat colored triangle and scans its vertex bounding box, one
// tested position per step transaction.
// ----------------------------------------------------------------------------
// Usage. A transaction is taken at a rising edge where start is high and
// busy is low. With in_req_type low it loads three vertices and a color,
// replaces any scan in progress and restarts at the box corner (min x,
// min y). With in_req_type high it advances the scan by one position; a
// step while no scan is active gives nothing. The scan runs x as the outer
// loop and y as the inner loop, and ends after the position flagged by
// out_last_pos.
// Each result is shown for exactly one cycle with out_strobe high, and is
// taken at the edge that closes that cycle; the consumer cannot hold it off.
// A step passes the command queue, the scan sequencer and the stage 1,
// stage 2 and result registers. Throughput is one transaction per clock:
// the scan sequencer advances one position per queued step, and the edge
// test behind it is fully pipelined. The two-entry command queue drains every
// cycle, so it never holds more than one entry and busy stays low.
// Reset (rst_n low, synchronous) empties the queue, idles the scan and
// clears the result strobe; no position is emitted until a load arrives.
// ----------------------------------------------------------------------------
`default_nettype none

module edge_function_triangle_raster (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  output logic                 busy,
  input  wire logic            in_req_type,
  input  wire efr_pkg::coord_t in_ax,
  input  wire efr_pkg::coord_t in_ay,
  input  wire efr_pkg::coord_t in_bx,
  input  wire efr_pkg::coord_t in_by_coord,
  input  wire efr_pkg::coord_t in_cx,
  input  wire efr_pkg::coord_t in_cy,
  input  wire efr_pkg::color_t in_fill_color,
  output logic                 out_strobe,
  output efr_pkg::coord_t      out_pos_x,
  output efr_pkg::coord_t      out_pos_y,
  output logic                 out_covered,
  output efr_pkg::color_t      out_pixel_color,
  output logic                 out_last_pos
);

  efr_pkg::cmd_deq_t deq;
  efr_pkg::issue_t   issue;
  efr_pkg::result_t  result;

  // Front: intake, classification and the command queue.
  efr_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_req_type   (in_req_type),
    .in_ax         (in_ax),
    .in_ay         (in_ay),
    .in_bx         (in_bx),
    .in_by_coord   (in_by_coord),
    .in_cx         (in_cx),
    .in_cy         (in_cy),
    .in_fill_color (in_fill_color),
    .deq           (deq)
  );

  // Back, first part: triangle store and the box walk.
  efr_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .deq   (deq),
    .issue (issue)
  );

  // Back, second part: the edge function of each triangle edge and the coverage decision.
  efr_edge u_edge (
    .clk    (clk),
    .rst_n  (rst_n),
    .issue  (issue),
    .result (result)
  );

  assign out_strobe      = result.strobe;
  assign out_pos_x       = result.pos_x;
  assign out_pos_y       = result.pos_y;
  assign out_covered     = result.covered;
  assign out_pixel_color = result.color;
  assign out_last_pos    = result.last;

endmodule

`default_nettype wire
